@@ hdl/crtr_pkg.sv @@
// shared types, codes and letter table for the cyrillic transliterator
`timescale 1ns / 1ps
package crtr_pkg;

	localparam logic [7:0] LeadD0      = 8'hD0;
	localparam logic [7:0] LeadD1      = 8'hD1;
	localparam logic [7:0] Terminator  = 8'h00;
	localparam logic [7:0] D0SpanLo    = 8'h90;
	localparam logic [7:0] D0SpanHi    = 8'hBF;
	localparam logic [7:0] D1SpanLo    = 8'h80;
	localparam logic [7:0] D1SpanHi    = 8'h8F;
	localparam logic [7:0] YoUpperLo   = 8'h81;
	localparam logic [7:0] YoLowerLo   = 8'h91;
	localparam int         QueueDepth  = 4;
	localparam int         QueuePtrW   = $clog2(QueueDepth);

	// one run of 1 to 3 output characters, chars[0] goes out first
	typedef struct packed {
		logic [2:0][7:0] chars;
		logic [1:0]      cnt;
	} run_t;

	function automatic run_t mk_run(input logic [1:0] n, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2);
		run_t r;
		r.cnt      = n;
		r.chars[0] = c0;
		r.chars[1] = c1;
		r.chars[2] = c2;
		return r;
	endfunction

	// upper half of the table; the lower half is the same with the first letter in lower case
	function automatic run_t upper_entry(input logic [4:0] idx);
		run_t r;
		unique case (idx)
			5'd0:  r = mk_run(2'd1, "A", 8'h00, 8'h00);
			5'd1:  r = mk_run(2'd1, "B", 8'h00, 8'h00);
			5'd2:  r = mk_run(2'd1, "V", 8'h00, 8'h00);
			5'd3:  r = mk_run(2'd1, "G", 8'h00, 8'h00);
			5'd4:  r = mk_run(2'd1, "D", 8'h00, 8'h00);
			5'd5:  r = mk_run(2'd1, "E", 8'h00, 8'h00);
			5'd6:  r = mk_run(2'd2, "Z", "h", 8'h00);
			5'd7:  r = mk_run(2'd1, "Z", 8'h00, 8'h00);
			5'd8:  r = mk_run(2'd1, "I", 8'h00, 8'h00);
			5'd9:  r = mk_run(2'd1, "J", 8'h00, 8'h00);
			5'd10: r = mk_run(2'd1, "K", 8'h00, 8'h00);
			5'd11: r = mk_run(2'd1, "L", 8'h00, 8'h00);
			5'd12: r = mk_run(2'd1, "M", 8'h00, 8'h00);
			5'd13: r = mk_run(2'd1, "N", 8'h00, 8'h00);
			5'd14: r = mk_run(2'd1, "O", 8'h00, 8'h00);
			5'd15: r = mk_run(2'd1, "P", 8'h00, 8'h00);
			5'd16: r = mk_run(2'd1, "R", 8'h00, 8'h00);
			5'd17: r = mk_run(2'd1, "S", 8'h00, 8'h00);
			5'd18: r = mk_run(2'd1, "T", 8'h00, 8'h00);
			5'd19: r = mk_run(2'd1, "U", 8'h00, 8'h00);
			5'd20: r = mk_run(2'd1, "F", 8'h00, 8'h00);
			5'd21: r = mk_run(2'd1, "H", 8'h00, 8'h00);
			5'd22: r = mk_run(2'd2, "T", "s", 8'h00);
			5'd23: r = mk_run(2'd2, "C", "h", 8'h00);
			5'd24: r = mk_run(2'd2, "S", "h", 8'h00);
			5'd25: r = mk_run(2'd3, "S", "c", "h");
			5'd26: r = mk_run(2'd1, "/", 8'h00, 8'h00);
			5'd27: r = mk_run(2'd1, "Y", 8'h00, 8'h00);
			5'd28: r = mk_run(2'd1, "'", 8'h00, 8'h00);
			5'd29: r = mk_run(2'd1, "E", 8'h00, 8'h00);
			5'd30: r = mk_run(2'd2, "Y", "u", 8'h00);
			5'd31: r = mk_run(2'd2, "Y", "a", 8'h00);
		endcase
		return r;
	endfunction

	function automatic run_t letter_entry(input logic [5:0] idx);
		run_t r;
		r = upper_entry(idx[4:0]);
		// lower-case half: fold only real letters, leave / and ' alone
		if (idx[5] && r.chars[0] >= "A" && r.chars[0] <= "Z") begin
			r.chars[0] = r.chars[0] | 8'h20;
		end
		return r;
	endfunction

endpackage

@@ hdl/crtr_front.sv @@
// front end: holds the lead byte and classifies each request into a run of characters or none
`timescale 1ns / 1ps
module crtr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	output logic             run_push,
	output crtr_pkg::run_t   run_data
);

	logic lead_pending_q;
	logic lead_is_d1_q;
	logic is_lead;

	assign is_lead = (in_byte == crtr_pkg::LeadD0) || (in_byte == crtr_pkg::LeadD1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_is_d1_q   <= 1'b0;
		end else if (accept) begin
			if (!lead_pending_q && is_lead) begin
				lead_pending_q <= 1'b1;
				lead_is_d1_q   <= (in_byte == crtr_pkg::LeadD1);
			end else begin
				lead_pending_q <= 1'b0;
				lead_is_d1_q   <= 1'b0;
			end
		end
	end

	always_comb begin
		run_push = 1'b0;
		run_data = crtr_pkg::mk_run(2'd1, in_byte, 8'h00, 8'h00);
		if (!lead_pending_q) begin
			run_push = accept && !is_lead;
		end else begin
			priority if (in_byte == crtr_pkg::Terminator) begin
				run_push = accept;
			end else if (!lead_is_d1_q && in_byte >= crtr_pkg::D0SpanLo
					&& in_byte <= crtr_pkg::D0SpanHi) begin
				run_push = accept;
				run_data = crtr_pkg::letter_entry(6'(in_byte - crtr_pkg::D0SpanLo));
			end else if (lead_is_d1_q && in_byte >= crtr_pkg::D1SpanLo
					&& in_byte <= crtr_pkg::D1SpanHi) begin
				run_push = accept;
				run_data = crtr_pkg::letter_entry({2'b11, in_byte[3:0]});
			end else if (!lead_is_d1_q && in_byte == crtr_pkg::YoUpperLo) begin
				run_push = accept;
				run_data = crtr_pkg::mk_run(2'd2, "Y", "o", 8'h00);
			end else if (lead_is_d1_q && in_byte == crtr_pkg::YoLowerLo) begin
				run_push = accept;
				run_data = crtr_pkg::mk_run(2'd2, "y", "o", 8'h00);
			end else begin
				// any other pair is dropped
				run_push = 1'b0;
			end
		end
	end

endmodule

@@ hdl/crtr_queue.sv @@
// short queue of character runs between the front end and the emitter
`timescale 1ns / 1ps
module crtr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  crtr_pkg::run_t   wr_data,
	input  logic             rd_en,
	output crtr_pkg::run_t   rd_data,
	output logic             q_empty,
	output logic             q_full
);

	crtr_pkg::run_t                 mem_q [crtr_pkg::QueueDepth];
	logic [crtr_pkg::QueuePtrW-1:0] wr_ptr_q;
	logic [crtr_pkg::QueuePtrW-1:0] rd_ptr_q;
	logic [crtr_pkg::QueuePtrW:0]   count_q;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == (crtr_pkg::QueuePtrW+1)'(crtr_pkg::QueueDepth));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/crtr_back.sv @@
// emitter: walks the head run one character per request
`timescale 1ns / 1ps
module crtr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  crtr_pkg::run_t   head,
	input  logic             head_valid,
	input  logic             take,
	output logic             run_pop,
	output logic [7:0]       out_char,
	output logic             last_of_run
);

	logic [1:0] idx_q;

	assign out_char    = head.chars[idx_q];
	assign last_of_run = (idx_q == head.cnt - 2'd1);
	assign run_pop     = take && head_valid && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take && head_valid) begin
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

@@ hdl/cyrillic_utf8_transliterator.sv @@
// top level of the cyrillic utf-8 to latin transliterator
`timescale 1ns / 1ps
// Bytes go in through push/full and characters come out through empty/pop, one
// character per cycle while pop is high and empty is low. When nothing is waiting
// ahead of it, an accepted byte that gives characters shows its first one on the
// result ports in the next cycle. Plain bytes give one character, a lead byte
// (0xD0 or 0xD1) gives none, and the byte after a lead gives zero to three
// characters. The front end takes one byte every cycle while full is low; a
// four-run queue sits between it and the emitter, so full rises only when four
// runs are waiting. Sustained throughput is set by the emitter's one character
// per cycle: a two-byte letter gives one to three characters.
module cyrillic_utf8_transliterator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       last_of_run
);

	logic           accept;
	logic           run_push;
	logic           run_pop;
	crtr_pkg::run_t run_data;
	crtr_pkg::run_t head_run;

	assign accept = push && !full;

	crtr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.run_push (run_push),
		.run_data (run_data)
	);

	crtr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (run_push),
		.wr_data (run_data),
		.rd_en   (run_pop),
		.rd_data (head_run),
		.q_empty (empty),
		.q_full  (full)
	);

	crtr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_run),
		.head_valid  (!empty),
		.take        (pop),
		.run_pop     (run_pop),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	// every queued run carries at least one character
	a_run_not_blank: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> head_run.cnt != 2'd0)
		else $error("queued run has no characters");

	// runs enter the queue only on an accepted request
	a_push_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		run_push |-> accept)
		else $error("run written without an accepted byte");

	// a single-character run is always its own last character
	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && head_run.cnt == 2'd1) |-> last_of_run)
		else $error("single-character run not marked last");

	// a run leaves the queue exactly when its last character is taken
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		run_pop |-> (pop && !empty && last_of_run))
		else $error("run removed before its last character");

endmodule
